@@ rtl/cdp_pkg.sv @@
// Shared types and constants for the call depth profiler.
package cdp_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned DEPTH_W  = 6;
    localparam int unsigned SKIP_W   = 9;
    localparam logic [SKIP_W-1:0] SKIP_MAX = 9'd511;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROF_EN   = 2'd2;

    // Event kinds
    localparam logic CMD_CALL   = 1'b0;
    localparam logic CMD_RETURN = 1'b1;

    // Stream packing
    localparam int unsigned S_TDATA_W = 256;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 264;
    localparam int unsigned M_TUSER_W = 2;

    // Controller to datapath commands
    typedef struct packed {
        logic take;  // input transaction accepted this cycle
        logic calc;  // memory read data valid, form elapsed time
        logic emit;  // load the output register
    } cdp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } cdp_sts_t;

endpackage

@@ rtl/cdp_ctrl.sv @@
// Sequencer for the call depth profiler: accept, read, evaluate.
module cdp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  cdp_pkg::cdp_sts_t sts,
    output cdp_pkg::cdp_cmd_t cmd
);
    import cdp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EVAL = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.calc   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                // hold the result until the output register frees up
                cmd.emit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/cdp_dp.sv @@
// Datapath: configuration, stack counters, stack memories and result register.
module cdp_dp #(
    parameter int unsigned RET_DEPTH  = 256,
    parameter int unsigned PROF_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cdp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdp_pkg::WORD_W-1:0]    cfg_data,
    input  logic [cdp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [cdp_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [cdp_pkg::M_TUSER_W-1:0] m_tuser,
    input  cdp_pkg::cdp_cmd_t             cmd,
    output cdp_pkg::cdp_sts_t             sts
);
    import cdp_pkg::*;

    localparam int unsigned RA   = $clog2(RET_DEPTH);
    localparam int unsigned RC   = RA + 1;
    localparam int unsigned PA   = $clog2(PROF_DEPTH);
    localparam int unsigned PC   = PA + 1;
    localparam int unsigned CMPW = (PC > DEPTH_W) ? PC : DEPTH_W;
    localparam int unsigned PW   = 3 * WORD_W;

    // configuration
    logic [DEPTH_W-1:0] max_depth_reg;
    logic [WORD_W-1:0]  cost_min_reg;
    logic               prof_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_depth_reg <= DEPTH_W'(3);
            cost_min_reg  <= WORD_W'(10);
            prof_en_reg   <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_DEPTH: max_depth_reg <= cfg_data[DEPTH_W-1:0];
                CFG_COST_MIN:  cost_min_reg  <= cfg_data;
                CFG_PROF_EN:   prof_en_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [WORD_W-1:0] in_class, in_sel, in_raddr, in_ts;
    logic              in_ret, in_main;

    assign in_class = s_tdata[WORD_W-1:0];
    assign in_sel   = s_tdata[2*WORD_W-1:WORD_W];
    assign in_raddr = s_tdata[3*WORD_W-1:2*WORD_W];
    assign in_ts    = s_tdata[4*WORD_W-1:3*WORD_W];
    assign in_ret   = (s_tuser[0] == CMD_RETURN);
    assign in_main  = s_tuser[1];

    // counters
    logic [RC-1:0]     ret_count_reg, ret_count_next;
    logic [PC-1:0]     prof_count_reg, prof_count_next;
    logic [SKIP_W-1:0] skip_count_reg, skip_count_next;

    logic profiled, prof_full, ret_room, ret_any, prof_any;
    logic ret_we, ret_re, prof_we, prof_re;
    logic [RA-1:0] ret_addr;
    logic [PA-1:0] prof_addr;
    logic [CMPW-1:0] pc_ext, md_ext;

    assign profiled = prof_en_reg & in_main;
    assign pc_ext   = CMPW'(prof_count_reg);
    assign md_ext   = CMPW'(max_depth_reg);
    assign prof_full = (pc_ext > md_ext) || (prof_count_reg >= PC'(PROF_DEPTH));
    assign ret_room = ret_count_reg < RC'(RET_DEPTH);
    assign ret_any  = ret_count_reg != '0;
    assign prof_any = prof_count_reg != '0;

    always_comb begin
        ret_count_next  = ret_count_reg;
        prof_count_next = prof_count_reg;
        skip_count_next = skip_count_reg;
        ret_we  = 1'b0;
        ret_re  = 1'b0;
        prof_we = 1'b0;
        prof_re = 1'b0;
        ret_addr  = ret_count_reg[RA-1:0];
        prof_addr = prof_count_reg[PA-1:0];
        if (cmd.take) begin
            if (!in_ret) begin
                if (profiled) begin
                    if (prof_full) begin
                        if (skip_count_reg < SKIP_MAX) begin
                            skip_count_next = skip_count_reg + 1'b1;
                        end
                    end else begin
                        prof_we         = 1'b1;
                        prof_count_next = prof_count_reg + 1'b1;
                    end
                end
                if (ret_room) begin
                    ret_we         = 1'b1;
                    ret_count_next = ret_count_reg + 1'b1;
                end
            end else begin
                if (profiled) begin
                    if (skip_count_reg != '0) begin
                        skip_count_next = skip_count_reg - 1'b1;
                    end else if (prof_any) begin
                        prof_re         = 1'b1;
                        prof_count_next = prof_count_reg - 1'b1;
                        prof_addr       = prof_count_next[PA-1:0];
                    end
                end
                if (ret_any) begin
                    ret_re         = 1'b1;
                    ret_count_next = ret_count_reg - 1'b1;
                    ret_addr       = ret_count_next[RA-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ret_count_reg  <= '0;
            prof_count_reg <= '0;
            skip_count_reg <= '0;
        end else begin
            ret_count_reg  <= ret_count_next;
            prof_count_reg <= prof_count_next;
            skip_count_reg <= skip_count_next;
        end
    end

    // stack memories, registered read
    logic [WORD_W-1:0] ret_mem [RET_DEPTH];
    logic [PW-1:0]     prof_mem [PROF_DEPTH];
    logic [WORD_W-1:0] ret_rdata_reg;
    logic [PW-1:0]     prof_rdata_reg;

    always_ff @(posedge aclk) begin
        if (ret_we) begin
            ret_mem[ret_addr] <= in_raddr;
        end
        if (ret_re) begin
            ret_rdata_reg <= ret_mem[ret_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (prof_we) begin
            prof_mem[prof_addr] <= {in_ts, in_sel, in_class};
        end
        if (prof_re) begin
            prof_rdata_reg <= prof_mem[prof_addr];
        end
    end

    // per-transaction flags
    logic               ret_ok_reg, fault_reg, pop_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [WORD_W-1:0]  ts_reg, cost_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            ret_ok_reg <= ret_re;
            fault_reg  <= in_ret ? !ret_any : !ret_room;
            pop_reg    <= prof_re;
            depth_reg  <= DEPTH_W'(prof_addr);
            ts_reg     <= in_ts;
        end
        if (cmd.calc) begin
            cost_reg <= ts_reg - prof_rdata_reg[PW-1:2*WORD_W];
        end
    end

    // result register
    logic               out_valid_reg;
    logic [WORD_W-1:0]  saved_reg, rcls_reg, rsel_reg, rcost_reg;
    logic [DEPTH_W-1:0] rdepth_reg;
    logic               rfault_reg, rvalid_reg;
    logic               hit;

    assign hit = pop_reg && (cost_reg >= cost_min_reg);
    assign sts.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            saved_reg  <= ret_ok_reg ? ret_rdata_reg : '0;
            rfault_reg <= fault_reg;
            rvalid_reg <= hit;
            rcls_reg   <= hit ? prof_rdata_reg[WORD_W-1:0] : '0;
            rsel_reg   <= hit ? prof_rdata_reg[2*WORD_W-1:WORD_W] : '0;
            rdepth_reg <= hit ? depth_reg : '0;
            rcost_reg  <= hit ? cost_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, rcost_reg, rdepth_reg, rsel_reg, rcls_reg, saved_reg};
    assign m_tuser  = {rvalid_reg, rfault_reg};

`ifndef SYNTHESIS
    a_ret_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ret_count_reg <= RC'(RET_DEPTH))
        else $error("return stack count past depth");

    a_prof_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        prof_count_reg <= PC'(PROF_DEPTH))
        else $error("profile stack count past depth");

    a_call_push: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take && !in_ret && ret_room |=> ret_count_reg == $past(ret_count_reg) + 1'b1)
        else $error("call did not push return stack");

    a_no_record_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !rvalid_reg |-> rcost_reg == '0 && rdepth_reg == '0)
        else $error("record fields nonzero without record");
`endif

endmodule

@@ rtl/call_depth_profiler_top.sv @@
// Top level of the call depth profiler: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_tvalid / s_tready | s_tdata events, s_tuser cmd + on_main
//  m_      | out       | m_tvalid / m_tready | m_tdata record, m_tuser fault + valid
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each event steps through accept, stack memory read, then evaluate and load the
// result register; the stack memories are single-port with registered reads.
// The next event is accepted while a result waits on m_tready; a stalled output
// holds the sequencer in its evaluate step.
// Reset (aresetn low, synchronous) empties both stacks and the skip counter
// and restores the register defaults; stack memories are not cleared.
module call_depth_profiler_top #(
    parameter int unsigned RET_DEPTH  = 256,
    parameter int unsigned PROF_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cdp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cdp_pkg::WORD_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // class_id, selector, return_addr, timestamp
    input  logic [cdp_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd, on_main
    input  logic [cdp_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // saved_return, rec_class, rec_selector, rec_depth, rec_cost, 2 zero bits
    output logic [cdp_pkg::M_TDATA_W-1:0] m_tdata,
    // stack_fault, record_valid
    output logic [cdp_pkg::M_TUSER_W-1:0] m_tuser
);
    import cdp_pkg::*;

    cdp_cmd_t cmd;
    cdp_sts_t sts;

    cdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cdp_dp #(
        .RET_DEPTH  (RET_DEPTH),
        .PROF_DEPTH (PROF_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
